@@ sv/mmul_pkg.sv @@
// Shared types and constants for the streaming matrix multiplier.
`default_nettype none

package mmul_pkg;

    // Fixed field widths of the external ports.
    localparam int VALUE_W = 16;
    localparam int ENTRY_W = 34;
    localparam int IDX_W   = 2;
    localparam int PROD_W  = 2 * VALUE_W;

    // Control bits that travel with each classified value.
    typedef struct packed {
        logic sel_b;   // value belongs to matrix B
        logic last;    // final value of matrix B
    } ctl_t;

    // One result as it waits in the result queue.
    typedef struct packed {
        logic signed [ENTRY_W-1:0] entry;
        logic [IDX_W-1:0]          row;
        logic [IDX_W-1:0]          col;
        logic                      last;
    } res_t;

    // Back-end sequencer states.
    typedef enum logic {
        BK_LOAD,
        BK_CALC
    } back_state_t;

endpackage : mmul_pkg

`default_nettype wire

@@ sv/mmul_fifo.sv @@
// Small register-based first-in first-out queue.
`default_nettype none

module mmul_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CNTW-1:0]  count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full  = (count_reg == CNTW'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rdata = mem_reg[rd_ptr_reg];

    // Storage is written at the write pointer.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Pointers wrap at the depth; the count tracks occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule : mmul_fifo

`default_nettype wire

@@ sv/mmul_front.sv @@
// Front end: counts incoming values and tags each with its store and index.
`default_nettype none

module mmul_front
    import mmul_pkg::*;
#(
    parameter int DIM = 4
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 push,
    output logic                                      full,
    input  wire logic signed [VALUE_W-1:0]            value,
    input  wire logic                                 cmd_full,
    output logic                                      cmd_push,
    output logic signed [VALUE_W-1:0]                 cmd_value,
    output ctl_t                                      cmd_ctl,
    output logic [$clog2(DIM*DIM)-1:0]                cmd_index
);

    localparam int CELLS = DIM * DIM;
    localparam int CW    = $clog2(CELLS);
    localparam int LW    = $clog2(2 * CELLS);

    logic [LW-1:0] load_count_reg;
    logic [LW-1:0] load_count_next;
    logic          is_b;
    logic          is_last;

    // A request is taken whenever the command queue has room.
    assign full     = cmd_full;
    assign cmd_push = push && !cmd_full;

    // Classify the value by its position in the run.
    assign is_b      = (load_count_reg >= LW'(CELLS));
    assign is_last   = (load_count_reg == LW'(2 * CELLS - 1));
    assign cmd_value = value;
    assign cmd_index = is_b ? CW'(load_count_reg - LW'(CELLS)) : CW'(load_count_reg);
    assign cmd_ctl   = '{sel_b: is_b, last: is_last};

    assign load_count_next = is_last ? '0 : load_count_reg + 1'b1;

    // The load counter returns to zero after the final value of B.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg <= '0;
        end
        else if (cmd_push)
        begin
            load_count_reg <= load_count_next;
        end
    end

endmodule : mmul_front

`default_nettype wire

@@ sv/mmul_back.sv @@
// Back end: operand stores and a pipelined multiply-accumulate over each entry.
`default_nettype none

module mmul_back
    import mmul_pkg::*;
#(
    parameter int DIM = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_empty,
    output logic                               cmd_pop,
    input  wire logic signed [VALUE_W-1:0]     cmd_value,
    input  wire ctl_t                          cmd_ctl,
    input  wire logic [$clog2(DIM*DIM)-1:0]    cmd_index,
    input  wire logic                          res_full,
    output logic                               res_push,
    output res_t                               res_data
);

    localparam int CELLS = DIM * DIM;
    localparam int CW    = $clog2(CELLS);
    localparam int IW    = $clog2(DIM);

    back_state_t state_reg;
    back_state_t state_next;

    logic signed [VALUE_W-1:0] store_a [CELLS];
    logic signed [VALUE_W-1:0] store_b [CELLS];

    logic [IW-1:0] row_reg;
    logic [IW-1:0] col_reg;
    logic [IW-1:0] k_reg;
    logic          issue;
    logic          k_end;
    logic          col_end;
    logic          row_end;
    logic          run_done;
    logic [CW-1:0] a_addr;
    logic [CW-1:0] b_addr;

    // Read stage.
    logic signed [VALUE_W-1:0] a_rd_reg;
    logic signed [VALUE_W-1:0] b_rd_reg;
    logic          rd_vld_reg;
    logic          rd_first_reg;
    logic          rd_last_reg;
    logic          rd_end_reg;
    logic [IW-1:0] rd_row_reg;
    logic [IW-1:0] rd_col_reg;

    // Multiply stage.
    logic signed [PROD_W-1:0] prod_reg;
    logic          mul_vld_reg;
    logic          mul_first_reg;
    logic          mul_last_reg;
    logic          mul_end_reg;
    logic [IW-1:0] mul_row_reg;
    logic [IW-1:0] mul_col_reg;

    // Accumulate stage.
    logic signed [ENTRY_W-1:0] acc_reg;
    logic signed [ENTRY_W-1:0] acc_sum;

    assign k_end    = (k_reg == IW'(DIM - 1));
    assign col_end  = (col_reg == IW'(DIM - 1));
    assign row_end  = (row_reg == IW'(DIM - 1));
    assign run_done = issue && k_end && col_end && row_end;

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_LOAD:
            begin
                if (!cmd_empty && cmd_ctl.last)
                begin
                    state_next = BK_CALC;
                end
            end
            BK_CALC:
            begin
                if (run_done)
                begin
                    state_next = BK_LOAD;
                end
            end
            default:
            begin
                state_next = BK_LOAD;
            end
        endcase
    end

    // Output logic of the sequencer. A new entry starts only when the
    // pipeline is empty and the result queue has a free slot.
    always_comb
    begin
        cmd_pop = 1'b0;
        issue   = 1'b0;
        unique case (state_reg)
            BK_LOAD:
            begin
                cmd_pop = !cmd_empty;
            end
            BK_CALC:
            begin
                issue = (k_reg != '0) || (!rd_vld_reg && !mul_vld_reg && !res_full);
            end
            default:
            begin
                cmd_pop = 1'b0;
                issue   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Entry and term counters walk rows, columns and terms in order.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
            k_reg   <= '0;
        end
        else if (issue)
        begin
            if (k_end)
            begin
                k_reg <= '0;
                if (col_end)
                begin
                    col_reg <= '0;
                    row_reg <= row_end ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            else
            begin
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    assign a_addr = CW'(row_reg) * CW'(DIM) + CW'(k_reg);
    assign b_addr = CW'(k_reg) * CW'(DIM) + CW'(col_reg);

    // Operand stores: written from the command queue, read with registered data.
    always_ff @(posedge clk)
    begin
        if (cmd_pop && !cmd_ctl.sel_b)
        begin
            store_a[cmd_index] <= cmd_value;
        end
        if (cmd_pop && cmd_ctl.sel_b)
        begin
            store_b[cmd_index] <= cmd_value;
        end
        if (issue)
        begin
            a_rd_reg <= store_a[a_addr];
            b_rd_reg <= store_b[b_addr];
        end
    end

    // Pipeline valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg  <= issue;
            mul_vld_reg <= rd_vld_reg;
        end
    end

    // Tags and product travel alongside the operands.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_first_reg <= (k_reg == '0);
            rd_last_reg  <= k_end;
            rd_end_reg   <= k_end && col_end && row_end;
            rd_row_reg   <= row_reg;
            rd_col_reg   <= col_reg;
        end
        if (rd_vld_reg)
        begin
            prod_reg      <= a_rd_reg * b_rd_reg;
            mul_first_reg <= rd_first_reg;
            mul_last_reg  <= rd_last_reg;
            mul_end_reg   <= rd_end_reg;
            mul_row_reg   <= rd_row_reg;
            mul_col_reg   <= rd_col_reg;
        end
        if (mul_vld_reg)
        begin
            acc_reg <= acc_sum;
        end
    end

    // The running sum wraps at the entry width.
    assign acc_sum = (mul_first_reg ? '0 : acc_reg)
                   + {{(ENTRY_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    assign res_push = mul_vld_reg && mul_last_reg;
    assign res_data = '{entry: acc_sum,
                        row:   IDX_W'(mul_row_reg),
                        col:   IDX_W'(mul_col_reg),
                        last:  mul_end_reg};

endmodule : mmul_back

`default_nettype wire

@@ sv/matrix_multiply_4x4_top.sv @@
// Top level of the streaming matrix multiplier: front end, queues and back end.
//
//  Channel   Direction  Handshake     Payload
//  input     in         push / full   value (16-bit signed, A then B, row-major)
//  result    out        pop / empty   product_entry, row_index, col_index, last_of_run
//
// Each input request is taken while the command queue has room.
// A product entry is formed from DIM term issues; the store-read and multiply
// stages then drain before the next entry starts, so entries run one after
// another. While the back end computes, the command queue fills and full
// rises. A full result queue holds off the next entry. Reset clears all control
// state; the operand stores are not cleared and are always rewritten before use.
`default_nettype none

module matrix_multiply_4x4_top
    import mmul_pkg::*;
#(
    parameter int DIM       = 4,
    parameter int CMD_DEPTH = 2,
    parameter int RES_DEPTH = 2
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    output logic                           full,
    input  wire logic signed [VALUE_W-1:0] value,
    output logic                           empty,
    input  wire logic                      pop,
    output logic signed [ENTRY_W-1:0]      product_entry,
    output logic [IDX_W-1:0]               row_index,
    output logic [IDX_W-1:0]               col_index,
    output logic                           last_of_run
);

    localparam int CW    = $clog2(DIM * DIM);
    localparam int CMD_W = VALUE_W + $bits(ctl_t) + CW;
    localparam int RES_W = $bits(res_t);

    // Front end to command queue.
    logic                      cmd_push;
    logic                      cmd_full;
    logic signed [VALUE_W-1:0] fe_value;
    ctl_t                      fe_ctl;
    logic [CW-1:0]             fe_index;
    logic [CMD_W-1:0]          cmd_wdata;

    // Command queue to back end.
    logic                      cmd_pop;
    logic                      cmd_empty;
    logic [CMD_W-1:0]          cmd_rdata;
    logic signed [VALUE_W-1:0] be_value;
    ctl_t                      be_ctl;
    logic [CW-1:0]             be_index;

    // Back end to result queue.
    logic                      res_push;
    logic                      res_full;
    res_t                      res_wdata;
    logic [RES_W-1:0]          res_rdata;
    res_t                      res_head;

    mmul_front #(
        .DIM (DIM)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .value     (value),
        .cmd_full  (cmd_full),
        .cmd_push  (cmd_push),
        .cmd_value (fe_value),
        .cmd_ctl   (fe_ctl),
        .cmd_index (fe_index)
    );

    assign cmd_wdata = {fe_value, fe_ctl, fe_index};

    mmul_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (cmd_push),
        .wdata (cmd_wdata),
        .full  (cmd_full),
        .rd_en (cmd_pop),
        .rdata (cmd_rdata),
        .empty (cmd_empty)
    );

    assign {be_value, be_ctl, be_index} = cmd_rdata;

    mmul_back #(
        .DIM (DIM)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd_value (be_value),
        .cmd_ctl   (be_ctl),
        .cmd_index (be_index),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_wdata)
    );

    mmul_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (res_push),
        .wdata (res_wdata),
        .full  (res_full),
        .rd_en (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    // The head of the result queue drives the result ports.
    assign res_head      = res_rdata;
    assign product_entry = res_head.entry;
    assign row_index     = res_head.row;
    assign col_index     = res_head.col;
    assign last_of_run   = res_head.last;

endmodule : matrix_multiply_4x4_top

`default_nettype wire

@@ sim/mmul_product_checker.sv @@
// Checker for the matrix multiplier: predicts every product entry and compares popped results.
`default_nettype none

module mmul_product_checker
    import mmul_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    input  wire logic                      full,
    input  wire logic signed [VALUE_W-1:0] value,
    input  wire logic                      empty,
    input  wire logic                      pop,
    input  wire logic signed [ENTRY_W-1:0] product_entry,
    input  wire logic [IDX_W-1:0]          row_index,
    input  wire logic [IDX_W-1:0]          col_index,
    input  wire logic                      last_of_run,
    output int                             failures,
    output int                             awaiting,
    output int                             entries_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE  = 4;
    localparam int CELLS = SIDE * SIDE;
    localparam int REPORT_LIMIT = 10;

    // Our own copy of the two operand matrices and the load position.
    logic signed [VALUE_W-1:0] mat_a [CELLS];
    logic signed [VALUE_W-1:0] mat_b [CELLS];
    int unsigned               load_pos = 0;

    // Product entries still to come out of the block, oldest first.
    res_t pending_entries [$];

    int fail_count = 0;
    int pop_count  = 0;

    // Count a failure; only the first few are described on the console.
    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
        begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    // Form C = A * B exactly and queue its entries in row-major order.
    task automatic queue_product();
        longint sum;
        res_t   ent;
        for (int r = 0; r < SIDE; r++)
        begin
            for (int c = 0; c < SIDE; c++)
            begin
                sum = 0;
                for (int k = 0; k < SIDE; k++)
                begin
                    sum += longint'(mat_a[r*SIDE + k]) * longint'(mat_b[k*SIDE + c]);
                end
                ent.entry = sum[ENTRY_W-1:0];
                ent.row   = IDX_W'(r);
                ent.col   = IDX_W'(c);
                ent.last  = (r == SIDE - 1) && (c == SIDE - 1);
                pending_entries.push_back(ent);
            end
        end
    endtask

    // Watch both channels at every rising edge once reset is released.
    always @(posedge clk)
    begin
        res_t want;
        res_t got;
        if (rst_n)
        begin
            // An accepted request loads A first, then B; the last B value triggers the product.
            if (push && !full)
            begin
                if (load_pos < CELLS)
                begin
                    mat_a[load_pos] = value;
                end
                else
                begin
                    mat_b[load_pos - CELLS] = value;
                end
                load_pos++;
                if (load_pos == 2 * CELLS)
                begin
                    queue_product();
                    load_pos = 0;
                end
            end

            // An accepted result must match the oldest outstanding entry field by field.
            if (pop && !empty)
            begin
                got.entry = product_entry;
                got.row   = row_index;
                got.col   = col_index;
                got.last  = last_of_run;
                pop_count++;
                if (pending_entries.size() == 0)
                begin
                    note_failure($sformatf("unexpected result: entry %0d row %0d col %0d last %0b",
                                           got.entry, got.row, got.col, got.last));
                end
                else
                begin
                    want = pending_entries.pop_front();
                    if (got !== want)
                    begin
                        note_failure($sformatf({"mismatch: expected entry %0d row %0d col %0d ",
                                                "last %0b, got entry %0d row %0d col %0d last %0b"},
                                               want.entry, want.row, want.col, want.last,
                                               got.entry, got.row, got.col, got.last));
                    end
                end
            end

            failures        <= fail_count;
            awaiting        <= pending_entries.size();
            entries_checked <= pop_count;
        end
    end

endmodule : mmul_product_checker

`default_nettype wire

@@ sim/testbench.sv @@
// Top of the matrix multiplier testbench: clock, reset, request stimulus and verdict.
`default_nettype none

module testbench
    import mmul_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS        = 16;
    localparam int RANDOM_RUNS  = 12;
    localparam int HOLD_START   = 400;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 100;

    localparam logic signed [VALUE_W-1:0] MOST_NEG = 16'sh8000;
    localparam logic signed [VALUE_W-1:0] MOST_POS = 16'sh7fff;

    // Kinds of matrix pair that the stimulus can produce.
    typedef enum int {
        RUN_TOP_PRODUCT,
        RUN_BOTTOM_PRODUCT,
        RUN_IDENTITY,
        RUN_CORNERS,
        RUN_NARROW,
        RUN_WIDE
    } run_kind_t;

    // Result-side stall patterns.
    typedef enum int {
        POP_ALWAYS,
        POP_MOSTLY,
        POP_RARELY,
        POP_COIN
    } pop_mode_t;

    logic                      clk   = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      push  = 1'b0;
    logic signed [VALUE_W-1:0] value = '0;
    logic                      pop   = 1'b0;
    logic                      full;
    logic                      empty;
    logic signed [ENTRY_W-1:0] product_entry;
    logic [IDX_W-1:0]          row_index;
    logic [IDX_W-1:0]          col_index;
    logic                      last_of_run;

    int failures;
    int awaiting;
    int entries_checked;

    int values_sent = 0;
    int pairs_sent  = 0;
    int burst_left  = 0;

    matrix_multiply_4x4_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .value         (value),
        .empty         (empty),
        .pop           (pop),
        .product_entry (product_entry),
        .row_index     (row_index),
        .col_index     (col_index),
        .last_of_run   (last_of_run)
    );

    mmul_product_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .value           (value),
        .empty           (empty),
        .pop             (pop),
        .product_entry   (product_entry),
        .row_index       (row_index),
        .col_index       (col_index),
        .last_of_run     (last_of_run),
        .failures        (failures),
        .awaiting        (awaiting),
        .entries_checked (entries_checked)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2_000_000;
        $display("testbench: errors");
        $finish;
    end

    // Element at position idx of a pair: A row-major in 0..15, B row-major in 16..31.
    function automatic logic signed [VALUE_W-1:0] pick_value(input run_kind_t kind,
                                                             input int idx);
        case (kind)
            RUN_TOP_PRODUCT:    return MOST_NEG;
            RUN_BOTTOM_PRODUCT: return (idx < CELLS) ? MOST_NEG : MOST_POS;
            RUN_IDENTITY:
            begin
                if (idx < CELLS)
                begin
                    return (idx % 5 == 0) ? 16'sd1 : 16'sd0;
                end
                return VALUE_W'($urandom());
            end
            RUN_CORNERS:
            begin
                case ($urandom_range(0, 5))
                    0:       return MOST_NEG;
                    1:       return MOST_POS;
                    2:       return 16'sd0;
                    3:       return -16'sd1;
                    4:       return 16'sd1;
                    default: return VALUE_W'($urandom());
                endcase
            end
            RUN_NARROW: return VALUE_W'($signed($urandom_range(0, 15)) - 8);
            default:    return VALUE_W'($urandom());
        endcase
    endfunction

    // Offer one value as a request, honoring the burst/gap pattern, and wait until it is taken.
    task automatic send_value(input logic signed [VALUE_W-1:0] v);
        if (burst_left == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
                                                      : $urandom_range(1, 20);
        end
        push  <= 1'b1;
        value <= v;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        burst_left--;
        values_sent++;
    endtask

    // Send one complete A, B pair.
    task automatic send_pair(input run_kind_t kind);
        for (int i = 0; i < 2 * CELLS; i++)
        begin
            send_value(pick_value(kind, i));
        end
        pairs_sent++;
    endtask

    // Result side: changing stall patterns, with one long hold-off that backs the block up.
    initial
    begin
        int        cycle_no;
        int        mode_left;
        pop_mode_t mode;
        cycle_no  = 0;
        mode_left = 0;
        mode      = POP_ALWAYS;
        forever
        begin
            @(posedge clk);
            cycle_no++;
            if (cycle_no >= HOLD_START && cycle_no < HOLD_START + HOLD_CYCLES)
            begin
                pop <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = pop_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(5, 80);
                end
                mode_left--;
                case (mode)
                    POP_ALWAYS: pop <= 1'b1;
                    POP_MOSTLY: pop <= ($urandom_range(0, 3) != 0);
                    POP_RARELY: pop <= ($urandom_range(0, 7) == 0);
                    default:    pop <= ($urandom_range(0, 1) == 1);
                endcase
            end
        end
    end

    // Reset, directed pairs, random pairs, drain and verdict.
    initial
    begin
        run_kind_t kind;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: largest and smallest possible entries, then an ordering check.
        send_pair(RUN_TOP_PRODUCT);
        send_pair(RUN_BOTTOM_PRODUCT);
        send_pair(RUN_IDENTITY);

        // Random part: mostly full-range content, some corner-heavy and some small values.
        for (int p = 0; p < RANDOM_RUNS; p++)
        begin
            case ($urandom_range(0, 3))
                0:       kind = RUN_CORNERS;
                1:       kind = RUN_NARROW;
                default: kind = RUN_WIDE;
            endcase
            send_pair(kind);
        end
        push <= 1'b0;

        // Let every outstanding product entry come out, then give the pipeline a margin.
        do
        begin
            @(posedge clk);
        end
        while (awaiting != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d values in %0d matrix pairs; checked %0d product entries.",
                 values_sent, pairs_sent, entries_checked);
        $display("Stimulus included extreme operands and a %0d-cycle result stall.", HOLD_CYCLES);
        if (failures == 0 && awaiting == 0)
        begin
            $display("testbench: clean");
        end
        else
        begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule : testbench

`default_nettype wire
